// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, included by led_mode_sos_beacon
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ledsos_pkg.sv -----
// ----------------------------------------------------------------------------
// ledsos_pkg
// types and constants of the lamp mode / sos beacon driver
// ----------------------------------------------------------------------------
package ledsos_pkg;

	localparam int COUNT_WIDTH_DEF = 16;

	localparam int UNIT_W      = 10;
	localparam int MASK_W      = 16;
	localparam int TICK_W      = 16;
	localparam int STEP_W      = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_BLINK = 2'd2,
		MODE_SOS   = 2'd3
	} mode_t;

	localparam logic REQ_TICK   = 1'b0;
	localparam logic REQ_BUTTON = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_UNIT_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_MASK = 1'd1;

	localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 10'd15;
	localparam logic [MASK_W-1:0] BLINK_MASK_RST = 16'd15;

	// last step of the pattern, and the steps followed by a letter gap
	localparam logic [STEP_W-1:0] STEP_LAST     = 5'd18;
	localparam logic [STEP_W-1:0] STEP_LETTER_A = 5'd7;
	localparam logic [STEP_W-1:0] STEP_LETTER_B = 5'd9;
	localparam logic [STEP_W-1:0] STEP_LETTER_C = 5'd11;
	localparam logic [STEP_W-1:0] STEP_FIRST    = 5'd0;

	typedef struct packed {
		mode_t              mode;
		logic               lamp;
		logic [STEP_W-1:0]  step;
	} ctl_t;

	typedef struct packed {
		logic [UNIT_W-1:0] unit_ticks;
		logic [MASK_W-1:0] blink_mask;
	} cfg_t;

endpackage

// ----- design/ledsos_cfg.sv -----
// ----------------------------------------------------------------------------
// ledsos_cfg
// configuration registers: sos unit length and blink mask
// ----------------------------------------------------------------------------
module ledsos_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ledsos_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [ledsos_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output ledsos_pkg::cfg_t                   cfg
);
	import ledsos_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_ticks <= UNIT_TICKS_RST;
			cfg_q.blink_mask <= BLINK_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_UNIT_TICKS: cfg_q.unit_ticks <= cfg_wdata[UNIT_W-1:0];
				REG_BLINK_MASK: cfg_q.blink_mask <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/ledsos_step.sv -----
// ----------------------------------------------------------------------------
// ledsos_step
// next-state logic for one request: mode button, blink and sos scheduling
// ----------------------------------------------------------------------------
module ledsos_step #(
	parameter int COUNT_WIDTH = ledsos_pkg::COUNT_WIDTH_DEF
) (
	input  logic                           req_type,
	input  logic [ledsos_pkg::TICK_W-1:0]  tick_count,
	input  ledsos_pkg::ctl_t               ctl_cur,
	input  logic [COUNT_WIDTH-1:0]         net_cur,
	input  ledsos_pkg::cfg_t               cfg,
	output ledsos_pkg::ctl_t               ctl_nxt,
	output logic [COUNT_WIDTH-1:0]         net_nxt
);
	import ledsos_pkg::*;

	localparam int GAP_W = UNIT_W + 3;
	localparam int DW    = ((COUNT_WIDTH > GAP_W) ? COUNT_WIDTH : GAP_W) + 2;

	logic [COUNT_WIDTH+TICK_W-1:0] tick_ext;
	logic [COUNT_WIDTH-1:0]        count;
	logic [COUNT_WIDTH+TICK_W-1:0] count_ext;
	logic [TICK_W-1:0]             count16;
	logic [GAP_W-1:0]              unit1;
	logic [GAP_W-1:0]              unit3;
	logic [GAP_W-1:0]              unit7;
	logic signed [DW-1:0]          diff;
	logic signed [DW-1:0]          limit;
	logic                          resync;
	logic                          fire;
	logic [GAP_W-1:0]              gap;
	logic [STEP_W-1:0]             step_base;

	// only the low COUNT_WIDTH bits of the tick count take part
	assign tick_ext  = {{COUNT_WIDTH{1'b0}}, tick_count};
	assign count     = tick_ext[COUNT_WIDTH-1:0];
	assign count_ext = {{TICK_W{1'b0}}, count};
	assign count16   = count_ext[TICK_W-1:0];

	assign unit1 = {3'b000, cfg.unit_ticks};
	assign unit3 = {2'b00, cfg.unit_ticks, 1'b0} + unit1;
	assign unit7 = {cfg.unit_ticks, 3'b000} - unit1;

	// signed distance past the scheduled event
	assign diff   = $signed(DW'(count)) - $signed(DW'(net_cur));
	assign limit  = $signed(DW'(unit7));
	assign resync = diff > limit;
	assign fire   = (count == net_cur);

	always_comb begin
		if (ctl_cur.step >= STEP_LAST) begin
			gap       = unit7;
			step_base = STEP_FIRST;
		end else if (ctl_cur.step == STEP_LETTER_A || ctl_cur.step == STEP_LETTER_B ||
				ctl_cur.step == STEP_LETTER_C) begin
			gap       = unit3;
			step_base = ctl_cur.step;
		end else begin
			gap       = unit1;
			step_base = ctl_cur.step;
		end
	end

	always_comb begin
		ctl_nxt = ctl_cur;
		net_nxt = net_cur;
		if (req_type == REQ_BUTTON) begin
			case (ctl_cur.mode)
				MODE_OFF: begin
					ctl_nxt.mode = MODE_ON;
					ctl_nxt.lamp = 1'b1;
				end
				MODE_ON:    ctl_nxt.mode = MODE_BLINK;
				MODE_BLINK: ctl_nxt.mode = MODE_SOS;
				MODE_SOS: begin
					ctl_nxt.mode = MODE_OFF;
					ctl_nxt.lamp = 1'b0;
				end
				default: ctl_nxt.mode = MODE_OFF;
			endcase
		end else if (ctl_cur.mode == MODE_BLINK) begin
			if ((count16 & cfg.blink_mask) == '0) begin
				ctl_nxt.lamp = ~ctl_cur.lamp;
			end
		end else if (ctl_cur.mode == MODE_SOS) begin
			if (resync) begin
				ctl_nxt.step = STEP_FIRST;
				net_nxt      = count + COUNT_WIDTH'(1);
			end else if (fire) begin
				// the first step always starts dark
				ctl_nxt.lamp = (ctl_cur.step == STEP_FIRST) ? 1'b0 : ~ctl_cur.lamp;
				ctl_nxt.step = step_base + STEP_W'(1);
				net_nxt      = count + COUNT_WIDTH'(gap);
			end
		end
	end

endmodule

// ----- design/led_mode_sos_beacon.sv -----
// ----------------------------------------------------------------------------
// led_mode_sos_beacon
// lamp driver with off, on, blink and sos modes, one result per request
// ----------------------------------------------------------------------------
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tuser = req_type, s_tdata = tick_count
// m_*       out  m_tvalid/m_tready   m_tdata = lamp_on, lamp_mode
// cfg_*     in   cfg_we              cfg_addr = register index, cfg_wdata
//
// one request per cycle while s_tready is high; each result passes through the
// input register, then the result register, once its request is taken
// mode state updates as the request leaves the input register
// a stalled result register holds the input register, which then drops s_tready
// reset clears mode, lamp, sos step and event time, and loads register defaults
// ----------------------------------------------------------------------------
module led_mode_sos_beacon #(
	parameter int COUNT_WIDTH = ledsos_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [ledsos_pkg::TICK_W-1:0]      s_tdata,   // [15:0] tick_count
	input  logic                               s_tuser,   // [0] req_type
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [ledsos_pkg::OUT_TDATA_W-1:0] m_tdata,   // [0] lamp_on, [2:1] lamp_mode
	input  logic                               cfg_we,
	input  logic [ledsos_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [ledsos_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ledsos_pkg::*;

	cfg_t                   cfg;
	logic                   valid_s1;
	logic                   req_s1;
	logic [TICK_W-1:0]      tick_s1;
	logic                   valid_s2;
	logic                   lamp_s2;
	mode_t                  mode_s2;
	ctl_t                   ctl_q;
	ctl_t                   ctl_nxt;
	logic [COUNT_WIDTH-1:0] net_q;
	logic [COUNT_WIDTH-1:0] net_nxt;
	logic                   adv;

	ledsos_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ledsos_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.req_type   (req_s1),
		.tick_count (tick_s1),
		.ctl_cur    (ctl_q),
		.net_cur    (net_q),
		.cfg        (cfg),
		.ctl_nxt    (ctl_nxt),
		.net_nxt    (net_nxt)
	);

	// request moves on when the result register is free or being emptied
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= s_tuser;
			tick_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lamp_s2 <= ctl_nxt.lamp;
			mode_s2 <= ctl_nxt.mode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode <= MODE_OFF;
			ctl_q.lamp <= 1'b0;
			ctl_q.step <= STEP_FIRST;
			net_q      <= '0;
		end else if (adv) begin
			ctl_q <= ctl_nxt;
			net_q <= net_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(OUT_TDATA_W-3){1'b0}}, mode_s2, lamp_s2};

`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !m_tvalid, "result valid during reset")
	`ASSERT_CLK(a_off_is_dark, m_tvalid && mode_s2 == MODE_OFF |-> !lamp_s2, "lamp lit in off mode")
	`ASSERT_CLK(a_on_is_lit, m_tvalid && mode_s2 == MODE_ON |-> lamp_s2, "lamp dark in on mode")
	`ASSERT_CLK(a_step_range, ctl_q.step <= STEP_LAST, "sos step beyond pattern end")
	`ASSERT_CLK(a_button_advances, adv && req_s1 == REQ_BUTTON |=> ctl_q.mode == mode_t'($past(ctl_q.mode) + 2'd1), "button did not advance mode")

endmodule

// ----- verif/led_mode_sos_beacon_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_mode_sos_beacon_tb
// drives button and tick requests into the lamp driver with random idling
// on both ports, predicts the lamp level and mode of every result and
// compares them in order; runs a short directed walk through the modes and
// then sequenced random phases under several register settings
// ----------------------------------------------------------------------------
module led_mode_sos_beacon_tb;
	import ledsos_pkg::*;

	typedef struct {
		logic              req_type;
		logic [TICK_W-1:0] tick_count;
	} beacon_req_t;

	typedef struct {
		logic  lamp;
		mode_t mode;
	} lamp_state_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b1;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [TICK_W-1:0]      s_tdata   = '0;
	logic                   s_tuser   = REQ_TICK;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr  = REG_UNIT_TICKS;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// predicted beacon state and register copies
	mode_t             mode_q  = MODE_OFF;
	logic              lamp_q  = 1'b0;
	logic [STEP_W-1:0] step_q  = STEP_FIRST;
	logic [TICK_W-1:0] evt_q   = '0;
	logic [UNIT_W-1:0] unit_q  = UNIT_TICKS_RST;
	logic [MASK_W-1:0] mask_q  = BLINK_MASK_RST;

	beacon_req_t beacon_reqs[$];
	lamp_state_t lamp_expected[$];

	int    reqs_queued    = 0;
	int    reqs_taken     = 0;
	int    results_seen   = 0;
	int    fail_count     = 0;
	int    send_wait      = 0;
	int    sink_wait      = 0;
	bit    no_idle        = 1'b0;
	bit    long_hold_done = 1'b0;

	// stimulus side mirror: mode after the queued buttons, running tick count
	mode_t             gen_mode = MODE_OFF;
	logic [TICK_W-1:0] tick_now = '0;

	led_mode_sos_beacon uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int pick_idle();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
	endfunction

	task automatic advance_lamp_model(input logic req, input logic [TICK_W-1:0] cnt);
		int diff;
		int gap;
		if (req == REQ_BUTTON) begin
			case (mode_q)
				MODE_OFF: begin
					mode_q = MODE_ON;
					lamp_q = 1'b1;
				end
				MODE_ON:    mode_q = MODE_BLINK;
				MODE_BLINK: mode_q = MODE_SOS;
				default: begin
					mode_q = MODE_OFF;
					lamp_q = 1'b0;
				end
			endcase
		end else if (mode_q == MODE_BLINK) begin
			if ((cnt & mask_q) == '0)
				lamp_q = ~lamp_q;
		end else if (mode_q == MODE_SOS) begin
			// signed distance of the zero-extended counts
			diff = int'(cnt) - int'(evt_q);
			if (diff > 7 * int'(unit_q)) begin
				step_q = STEP_FIRST;
				evt_q  = cnt + 1'b1;
			end else if (cnt == evt_q) begin
				if (step_q == STEP_FIRST)
					lamp_q = 1'b0;
				else
					lamp_q = ~lamp_q;
				if (step_q >= STEP_LAST) begin
					gap    = 7 * int'(unit_q);
					step_q = STEP_FIRST;
				end else if (step_q == STEP_LETTER_A || step_q == STEP_LETTER_B ||
						step_q == STEP_LETTER_C) begin
					gap = 3 * int'(unit_q);
				end else begin
					gap = int'(unit_q);
				end
				evt_q  = cnt + TICK_W'(gap);
				step_q = step_q + 1'b1;
			end
		end
		lamp_expected.push_back('{lamp: lamp_q, mode: mode_q});
	endtask

	task automatic queue_req(input logic req, input logic [TICK_W-1:0] cnt);
		beacon_reqs.push_back('{req_type: req, tick_count: cnt});
		reqs_queued++;
		if (req == REQ_BUTTON)
			gen_mode = mode_t'(gen_mode + 2'd1);
	endtask

	task automatic wait_drained();
		while (reqs_taken != reqs_queued || lamp_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		if (idx == REG_UNIT_TICKS)
			unit_q = val[UNIT_W-1:0];
		else
			mask_q = val[MASK_W-1:0];
	endtask

	task automatic set_regs(input logic [UNIT_W-1:0] unit, input logic [MASK_W-1:0] mask);
		write_reg(REG_UNIT_TICKS, CFG_DATA_W'(unit));
		write_reg(REG_BLINK_MASK, mask);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly steps of one unit so sos events land exactly, plus small steps and jumps
	task automatic step_tick(input logic [UNIT_W-1:0] unit);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			tick_now += TICK_W'(unit);
		else if (r < 85)
			tick_now += 1'b1;
		else if (r >= 92)
			tick_now = ($urandom_range(0, 3) == 0) ? '0 : TICK_W'($urandom);
	endtask

	task automatic gen_phase(input logic [UNIT_W-1:0] unit, input int goal);
		int    made;
		int    pick;
		int    run;
		bit    busy;
		mode_t target;
		made = 0;
		while (made < goal) begin
			pick   = $urandom_range(0, 99);
			target = (pick < 55) ? MODE_SOS : (pick < 85) ? MODE_BLINK :
				(pick < 95) ? MODE_ON : MODE_OFF;
			while (gen_mode != target) begin
				queue_req(REQ_BUTTON, TICK_W'($urandom));
				made++;
			end
			busy = (target == MODE_SOS || target == MODE_BLINK);
			run  = busy ? $urandom_range(8, 40) : $urandom_range(1, 4);
			repeat (run) begin
				// stray button now and then breaks the sequence
				if ($urandom_range(0, 32) == 0) begin
					queue_req(REQ_BUTTON, TICK_W'($urandom));
					made++;
				end
				step_tick(unit);
				queue_req(REQ_TICK, tick_now);
				if (gen_mode == MODE_SOS || gen_mode == MODE_BLINK)
					made++;
			end
		end
	endtask

	always @(posedge clk) begin : drive_reqs
		beacon_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_lamp_model(s_tuser, s_tdata);
				reqs_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (beacon_reqs.size() > 0) begin
					nxt = beacon_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= nxt.req_type;
					s_tdata  <= nxt.tick_count;
					if (!no_idle && $urandom_range(0, 3) == 0)
						send_wait = pick_idle();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_lamp
		lamp_state_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (lamp_expected.size() == 0) begin
					$error("result with nothing expected: m_tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = lamp_expected.pop_front();
					if (m_tdata[0] !== want.lamp) begin
						$error("lamp_on: expected %0b, actual %0b", want.lamp, m_tdata[0]);
						fail_count++;
					end
					if (m_tdata[2:1] !== want.mode) begin
						$error("lamp_mode: expected %0d, actual %0d", want.mode, m_tdata[2:1]);
						fail_count++;
					end
				end
			end
			if (sink_wait > 0) begin
				sink_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				// one long hold so the block backs up and drops s_tready
				if (results_seen >= 60 && !long_hold_done) begin
					long_hold_done = 1'b1;
					sink_wait = 120;
				end else if (!no_idle && $urandom_range(0, 4) == 0) begin
					sink_wait = pick_idle();
				end
			end
		end
	end

	initial begin
		// falling edge at time zero so the design resets before the first clock
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed walk with reset register values (unit 15, mask 15)
		queue_req(REQ_TICK, 16'h0000);     // off: tick ignored
		queue_req(REQ_TICK, 16'hFFFF);
		queue_req(REQ_BUTTON, 16'hFFFF);   // on lights the lamp
		queue_req(REQ_TICK, 16'h0000);     // on: tick ignored
		queue_req(REQ_BUTTON, 16'h0000);   // blink
		queue_req(REQ_TICK, 16'h0000);     // masked bits zero: toggle
		queue_req(REQ_TICK, 16'h0001);
		queue_req(REQ_TICK, 16'hFFF0);
		queue_req(REQ_BUTTON, 16'h5A5A);   // sos from step 0, event 0
		queue_req(REQ_TICK, 16'h0000);     // step 0 darkens
		queue_req(REQ_TICK, 16'h000F);     // next dot toggles
		queue_req(REQ_TICK, 16'h0005);     // behind the event time
		queue_req(REQ_TICK, 16'hFFFF);     // far past: resync, event wraps to 0
		queue_req(REQ_TICK, 16'h0000);
		queue_req(REQ_BUTTON, 16'hA5A5);   // off darkens
		queue_req(REQ_BUTTON, 16'h0000);
		queue_req(REQ_BUTTON, 16'hFFFF);
		queue_req(REQ_BUTTON, 16'h0001);   // back in sos, step and event kept
		queue_req(REQ_TICK, 16'h000F);
		queue_req(REQ_TICK, 16'd121);      // late but inside the resync window
		queue_req(REQ_TICK, 16'd136);      // just past the window: resync
		wait_drained();

		set_regs(10'd1, 16'hFFFF);
		tick_now = 16'hFF80;               // walk through the counter wrap
		gen_phase(10'd1, 125);
		wait_drained();

		set_regs(10'd1023, 16'h0001);
		no_idle = 1'b1;
		gen_phase(10'd1023, 125);
		wait_drained();
		no_idle = 1'b0;

		set_regs(10'd0, 16'h0000);
		gen_phase(10'd0, 125);
		wait_drained();

		set_regs(UNIT_W'($urandom_range(2, 8)), MASK_W'($urandom_range(1, 65535)));
		gen_phase(unit_q, 125);
		wait_drained();

		repeat (20) @(posedge clk);
		if (fail_count == 0 && lamp_expected.size() == 0)
			$display("led_mode_sos_beacon_tb passed");
		else
			$display("led_mode_sos_beacon_tb failed");
		$finish;
	end

	initial begin
		#400000;
		$display("led_mode_sos_beacon_tb failed");
		$finish;
	end

endmodule
